### rtl/c3s_pkg.sv
// Shared types and constants for the 3x3 convolution filter.
package c3s_pkg;

  localparam int PIX_W     = 8;
  localparam int DIM_W     = 12;
  localparam int COEF_W    = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = COEF_W;
  localparam int TAP_N     = 9;
  localparam int PROD_W    = 17;
  localparam int SUM_W     = 21;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_MIDDLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_BOTTOM  = 3'd4;

  // operation codes of an input item
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 12'd480;
  localparam logic [COEF_W-1:0] RST_COEF_TOP     = 24'h00FF00;
  localparam logic [COEF_W-1:0] RST_COEF_MIDDLE  = 24'hFF05FF;
  localparam logic [COEF_W-1:0] RST_COEF_BOTTOM  = 24'h00FF00;

  localparam logic [DIM_W-1:0]  DIM_MIN = 12'd3;
  localparam logic [PIX_W-1:0]  PIX_MAX = 8'hFF;

  typedef logic [PIX_W-1:0] pixel_t;

  // control that travels with an item down the pipeline
  typedef struct packed {
    logic store;  // pixel that updates line stores and window
    logic emit;   // result carries an output pixel
    logic calc;   // interior pixel, output is the filtered sum
    logic last;   // final output of the frame
  } stage_ctl_t;

endpackage

### rtl/c3s_in_if.sv
// Input channel of the filter: operation and pixel with valid/ready.
interface c3s_in_if;
  import c3s_pkg::*;

  logic   valid;
  logic   ready;
  logic   operation;
  pixel_t pixel;

  modport source (output valid, output operation, output pixel, input ready);
  modport sink   (input valid, input operation, input pixel, output ready);
endinterface

### rtl/c3s_out_if.sv
// Result channel of the filter: output pixel and flags with valid/ready.
interface c3s_out_if;
  import c3s_pkg::*;

  logic   valid;
  logic   ready;
  logic   out_valid;
  pixel_t out_pixel;
  logic   frame_last;

  modport source (output valid, output out_valid, output out_pixel, output frame_last,
                  input ready);
  modport sink   (input valid, input out_valid, input out_pixel, input frame_last,
                  output ready);
endinterface

### rtl/conv3x3_sharpen_filter.sv
// Top level: 3x3 convolution filter over a raster pixel stream with two line stores.
// Pipeline: an accepted item moves through stages 1, 2 and 3 into the output register.
// Throughput: one item per cycle; the pipeline stalls only while the output register
// holds a result that the sink has not taken.
// Reset: counters, window, pipeline valids and configuration return to defaults at once;
// the line stores are not cleared and need no clearing pass.
module conv3x3_sharpen_filter #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  c3s_in_if.sink                        item_i,
  c3s_out_if.source                     result_o,
  input  logic                          cfg_we_i,
  input  logic [c3s_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [c3s_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import c3s_pkg::*;

  // geometry bounded by the parameter and by the 12-bit registers
  localparam int WMAX = (MAX_WIDTH  > 4095) ? 4095 : MAX_WIDTH;
  localparam int HMAX = (MAX_HEIGHT > 4095) ? 4095 : MAX_HEIGHT;
  localparam int AW   = $clog2(WMAX);
  localparam int RW   = $clog2(HMAX + 1);
  localparam int TW   = $clog2(WMAX * HMAX + 1);
  localparam int CW   = TW + 1;
  localparam logic [DIM_W-1:0] WMAX_D = DIM_W'(WMAX);
  localparam logic [DIM_W-1:0] HMAX_D = DIM_W'(HMAX);

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < DIM_MIN) r = DIM_MIN;
    if (v > hi) r = hi;
    return r;
  endfunction

  // configuration
  logic [DIM_W-1:0]  image_width_q, image_height_q;
  logic [COEF_W-1:0] coef_top_q, coef_mid_q, coef_bot_q;
  logic [TW-1:0]     total_q;
  logic [DIM_W-1:0]  w_cur, h_cur;

  assign w_cur = clamp_dim(image_width_q, WMAX_D);
  assign h_cur = clamp_dim(image_height_q, HMAX_D);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= RST_IMAGE_WIDTH;
      image_height_q <= RST_IMAGE_HEIGHT;
      coef_top_q     <= RST_COEF_TOP;
      coef_mid_q     <= RST_COEF_MIDDLE;
      coef_bot_q     <= RST_COEF_BOTTOM;
      total_q        <= TW'(clamp_dim(RST_IMAGE_WIDTH, WMAX_D))
                        * TW'(clamp_dim(RST_IMAGE_HEIGHT, HMAX_D));
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH: begin
          image_width_q <= cfg_wdata_i[DIM_W-1:0];
          total_q <= TW'(clamp_dim(cfg_wdata_i[DIM_W-1:0], WMAX_D)) * TW'(h_cur);
        end
        CFG_IMAGE_HEIGHT: begin
          image_height_q <= cfg_wdata_i[DIM_W-1:0];
          total_q <= TW'(w_cur) * TW'(clamp_dim(cfg_wdata_i[DIM_W-1:0], HMAX_D));
        end
        CFG_COEF_TOP:    coef_top_q <= cfg_wdata_i;
        CFG_COEF_MIDDLE: coef_mid_q <= cfg_wdata_i;
        CFG_COEF_BOTTOM: coef_bot_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline enable: everything moves when the output register can take a result
  logic res_valid_q;
  logic adv;
  logic accept;

  assign adv          = !res_valid_q || result_o.ready;
  assign item_i.ready = adv;
  assign accept       = item_i.valid && adv;

  // stage 0: counters and decode
  logic [AW-1:0] in_col_q, in_col_d;
  logic [RW-1:0] in_row_q, in_row_d;
  logic [CW-1:0] out_count_q, out_count_d;
  stage_ctl_t    dec;
  logic [CW-1:0] count_inc;
  logic          row_open;

  assign count_inc = CW'(out_count_q + CW'(1));
  assign row_open  = DIM_W'(in_row_q) < h_cur;

  always_comb begin
    dec         = '0;
    in_col_d    = in_col_q;
    in_row_d    = in_row_q;
    out_count_d = out_count_q;
    if (item_i.operation == OP_PIXEL) begin
      if (row_open) begin
        dec.store = 1'b1;
        dec.emit  = (in_row_q >= RW'(2)) || (in_row_q == RW'(1) && in_col_q >= AW'(1));
        dec.calc  = (in_row_q >= RW'(2)) && (in_col_q >= AW'(2));
        if (dec.emit) out_count_d = count_inc;
        if (DIM_W'(in_col_q) + DIM_W'(1) >= w_cur) begin
          in_col_d = '0;
          in_row_d = RW'(in_row_q + RW'(1));
        end else begin
          in_col_d = AW'(in_col_q + AW'(1));
        end
      end
    end else if (!row_open) begin
      if (out_count_q < CW'(total_q)) begin
        dec.emit    = 1'b1;
        out_count_d = count_inc;
        if (count_inc >= CW'(total_q)) begin
          dec.last    = 1'b1;
          in_col_d    = '0;
          in_row_d    = '0;
          out_count_d = '0;
        end
      end else begin
        in_col_d    = '0;
        in_row_d    = '0;
        out_count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_count_q <= '0;
    end else if (accept) begin
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      out_count_q <= out_count_d;
    end
  end

  // stage 1: line store read data arrives, write back on advance
  logic          s1_valid_q;
  stage_ctl_t    s1_ctl_q;
  pixel_t        s1_px_q;
  logic [AW-1:0] s1_addr_q;
  pixel_t        up_rd_q, lo_rd_q;
  pixel_t        upper_mem [WMAX];
  pixel_t        lower_mem [WMAX];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      up_rd_q <= upper_mem[in_col_q];
      lo_rd_q <= lower_mem[in_col_q];
    end
    if (adv && s1_valid_q && s1_ctl_q.store) begin
      upper_mem[s1_addr_q] <= lo_rd_q;
      lower_mem[s1_addr_q] <= s1_px_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctl_q  <= dec;
      s1_px_q   <= item_i.pixel;
      s1_addr_q <= in_col_q;
    end
  end

  // stage 2: window holds the 3x3 neighborhood of the item in this stage
  logic       s2_valid_q;
  stage_ctl_t s2_ctl_q;
  pixel_t     win_q [TAP_N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAP_N; i++) win_q[i] <= '0;
    end else if (adv && s1_valid_q && s1_ctl_q.store) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]   <= win_q[r*3+1];
        win_q[r*3+1] <= win_q[r*3+2];
      end
      win_q[2] <= up_rd_q;
      win_q[5] <= lo_rd_q;
      win_q[8] <= s1_px_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) s2_ctl_q <= s1_ctl_q;
  end

  // stage 3: nine products
  logic                     s3_valid_q;
  stage_ctl_t               s3_ctl_q;
  logic signed [PROD_W-1:0] prod_q [TAP_N];
  logic signed [PROD_W-1:0] prod_d [TAP_N];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_d[c]   = PROD_W'($signed(coef_top_q[8*c +: 8]))
                    * PROD_W'($signed({1'b0, win_q[c]}));
      prod_d[3+c] = PROD_W'($signed(coef_mid_q[8*c +: 8]))
                    * PROD_W'($signed({1'b0, win_q[3+c]}));
      prod_d[6+c] = PROD_W'($signed(coef_bot_q[8*c +: 8]))
                    * PROD_W'($signed({1'b0, win_q[6+c]}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_ctl_q <= s2_ctl_q;
      for (int i = 0; i < TAP_N; i++) prod_q[i] <= prod_d[i];
    end
  end

  // output stage: sum, saturate, register the result
  logic signed [SUM_W-1:0] sum;
  pixel_t                  sat;
  pixel_t                  out_pixel_q;
  logic                    out_valid_q, frame_last_q;

  always_comb begin
    sum = '0;
    for (int i = 0; i < TAP_N; i++) sum = sum + SUM_W'(prod_q[i]);
    if (sum < 0) begin
      sat = '0;
    end else if (sum > SUM_W'(PIX_MAX)) begin
      sat = PIX_MAX;
    end else begin
      sat = sum[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_valid_q  <= s3_ctl_q.emit;
      frame_last_q <= s3_ctl_q.last;
      out_pixel_q  <= s3_ctl_q.calc ? sat : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= item_i.valid;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      res_valid_q <= s3_valid_q;
    end
  end

  assign result_o.valid      = res_valid_q;
  assign result_o.out_valid  = out_valid_q;
  assign result_o.out_pixel  = out_pixel_q;
  assign result_o.frame_last = frame_last_q;

endmodule

### rtl/c3s_port_check.sv
// Port-level assertions for the 3x3 convolution filter, bound to its top level.
module c3s_port_check (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_i,
  input logic                  res_valid_i,
  input logic                  res_ready_i,
  input logic                  res_out_valid_i,
  input logic [c3s_pkg::PIX_W-1:0] res_out_pixel_i,
  input logic                  res_frame_last_i
);
  import c3s_pkg::*;

  // a stalled result holds its payload
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      res_valid_i && $stable(res_out_valid_i) && $stable(res_out_pixel_i)
      && $stable(res_frame_last_i))
    else $error("result changed while stalled");

  // no new item is taken while the output register is blocked
  a_back_pressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |-> !in_ready_i)
    else $error("item accepted while result stalled");

  // frame end only on a result that carries a pixel
  a_last_carries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_frame_last_i |-> res_out_valid_i)
    else $error("frame_last without out_valid");

  // an empty result carries a zero pixel
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_out_valid_i |-> res_out_pixel_i == '0)
    else $error("nonzero pixel on empty result");

  // nothing comes out once reset has been applied at an edge
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !res_valid_i)
    else $error("result valid during reset");

endmodule

bind conv3x3_sharpen_filter c3s_port_check u_c3s_port_check (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (item_i.ready),
  .res_valid_i      (result_o.valid),
  .res_ready_i      (result_o.ready),
  .res_out_valid_i  (result_o.out_valid),
  .res_out_pixel_i  (result_o.out_pixel),
  .res_frame_last_i (result_o.frame_last)
);
